FILE: rtl/bcs_pkg.sv
package bcs_pkg;

    localparam int MAX_CELLS_DEF = 4096;

    localparam int SAMPLE_W = 32;
    localparam int IDX_W    = 12;
    localparam int COUNT_W  = 13;
    localparam int MODE_W   = 2;
    localparam int ADDR_W   = 4;
    localparam int APB_W    = 32;

    // stream data widths, padded to whole bytes
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 48;

    // result queue
    localparam int QUEUE_DEPTH = 4;
    localparam int MAX_RESULTS = 3;

    localparam logic [COUNT_W-1:0] CELL_COUNT_RST = 13'd4096;

    typedef enum logic [MODE_W-1:0] {
        MODE_PASS     = 2'd0,
        MODE_ANTI     = 2'd1,
        MODE_SYM      = 2'd2,
        MODE_PERIODIC = 2'd3
    } t_mode;

    // register index, taken from paddr[3:2]
    typedef enum logic [1:0] {
        REG_CELL_COUNT = 2'd0,
        REG_LEFT_MODE  = 2'd1,
        REG_RIGHT_MODE = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic                       frame_end;
        logic signed [SAMPLE_W-1:0] value;
        logic [IDX_W-1:0]           index;
    } t_result;

endpackage

FILE: rtl/binomial_charge_smoother.sv
// channel  | dir | handshake                        | payload
// ---------+-----+----------------------------------+--------------------------------------
// s stream | in  | i_s_tvalid / o_s_tready          | i_s_tdata: charge_sample
// m stream | out | o_m_tvalid / i_m_tready          | o_m_tdata: cell_index, smoothed_value;
//          |     |                                  | o_m_tlast: frame_end
// apb cfg  | in  | i_psel, i_penable, o_pready = 1  | i_paddr, i_pwdata, o_prdata
//
// one sample per cycle while o_s_tready is high; its results are formed by one level of adders and
// written to a four-entry result queue at the accepting edge
// first result visible in the cycle after the request is accepted; queue drains one per cycle while i_m_tready is high
// a frame-closing sample adds two or three results; o_s_tready drops while
// more than one result waits
// i_rst_n is synchronous, active low; clears counter and queue, resets registers to defaults
module binomial_charge_smoother #(
    parameter int MAX_CELLS = bcs_pkg::MAX_CELLS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // slave stream
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [bcs_pkg::S_TDATA_W-1:0]  i_s_tdata,  // [31:0] charge_sample
    // master stream
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [bcs_pkg::M_TDATA_W-1:0]  o_m_tdata,  // [11:0] cell_index, [43:12] smoothed_value
    output logic                           o_m_tlast,
    // configuration
    input  logic                           i_psel,
    input  logic                           i_penable,
    input  logic                           i_pwrite,
    input  logic [bcs_pkg::ADDR_W-1:0]     i_paddr,
    input  logic [bcs_pkg::APB_W-1:0]      i_pwdata,
    output logic [bcs_pkg::APB_W-1:0]      o_prdata,
    output logic                           o_pready
);

    localparam int CNT_W = (MAX_CELLS > 2) ? $clog2(MAX_CELLS) : 1;
    localparam int N_W   = $clog2(MAX_CELLS + 1);
    localparam int PTR_W = $clog2(bcs_pkg::QUEUE_DEPTH);
    localparam int QC_W  = PTR_W + 1;
    localparam int SW    = bcs_pkg::SAMPLE_W;
    localparam int AW    = SW + 2;

    // configuration
    logic [bcs_pkg::COUNT_W-1:0] r_cell_count;
    logic [bcs_pkg::MODE_W-1:0]  r_left_mode;
    logic [bcs_pkg::MODE_W-1:0]  r_right_mode;
    logic                        cfg_wr;
    bcs_pkg::t_reg_idx           reg_idx;

    assign o_pready = 1'b1;
    assign cfg_wr   = i_psel && i_penable && i_pwrite;
    assign reg_idx  = bcs_pkg::t_reg_idx'(i_paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_count <= bcs_pkg::CELL_COUNT_RST;
            r_left_mode  <= bcs_pkg::MODE_ANTI;
            r_right_mode <= bcs_pkg::MODE_ANTI;
        end else if (cfg_wr) begin
            case (reg_idx)
                bcs_pkg::REG_CELL_COUNT: r_cell_count <= i_pwdata[bcs_pkg::COUNT_W-1:0];
                bcs_pkg::REG_LEFT_MODE:  r_left_mode  <= i_pwdata[bcs_pkg::MODE_W-1:0];
                bcs_pkg::REG_RIGHT_MODE: r_right_mode <= i_pwdata[bcs_pkg::MODE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            bcs_pkg::REG_CELL_COUNT: o_prdata = bcs_pkg::APB_W'(r_cell_count);
            bcs_pkg::REG_LEFT_MODE:  o_prdata = bcs_pkg::APB_W'(r_left_mode);
            bcs_pkg::REG_RIGHT_MODE: o_prdata = bcs_pkg::APB_W'(r_right_mode);
            default:                 o_prdata = '0;
        endcase
    end

    // effective frame length, clamped to 2..MAX_CELLS
    logic [N_W-1:0] n_eff;
    always_comb begin
        if (r_cell_count < 2)
            n_eff = N_W'(2);
        else if (r_cell_count > MAX_CELLS)
            n_eff = N_W'(MAX_CELLS);
        else
            n_eff = N_W'(r_cell_count);
    end

    // sample history
    logic [CNT_W-1:0]       r_cnt;
    logic [CNT_W-1:0]       n_cnt;
    logic signed [SW-1:0]   r_first;
    logic signed [SW-1:0]   r_second;
    logic signed [SW-1:0]   r_older;
    logic signed [SW-1:0]   r_prev;

    logic signed [SW-1:0]   x;
    logic signed [SW-1:0]   second_eff;
    logic                   accept;
    logic                   held;
    logic                   last;
    logic                   k_is0;
    logic                   k_is1;

    assign x          = signed'(i_s_tdata[SW-1:0]);
    assign accept     = i_s_tvalid && o_s_tready;
    assign k_is0      = (r_cnt == '0);
    assign k_is1      = (r_cnt == CNT_W'(1));
    assign held       = (r_left_mode == bcs_pkg::MODE_PERIODIC);
    assign last       = (({1'b0, r_cnt} + 1'b1) >= n_eff) && !k_is0;
    assign second_eff = k_is1 ? x : r_second;
    assign n_cnt      = last ? '0 : r_cnt + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_first  <= '0;
            r_second <= '0;
            r_older  <= '0;
            r_prev   <= '0;
        end else if (accept) begin
            r_cnt   <= n_cnt;
            r_older <= r_prev;
            r_prev  <= x;
            if (k_is0) r_first  <= x;
            if (k_is1) r_second <= x;
        end
    end

    // floor(sum / 4) of the end formula; passthrough goes through unchanged
    function automatic logic signed [SW-1:0] f_end(
        input logic [bcs_pkg::MODE_W-1:0] mode,
        input logic signed [SW-1:0]       c,
        input logic signed [SW-1:0]       nb,
        input logic signed [SW-1:0]       w
    );
        logic signed [AW-1:0] s;
        case (mode)
            bcs_pkg::MODE_ANTI:     s = AW'(c) + AW'(nb);
            bcs_pkg::MODE_SYM:      s = AW'(c) + AW'(c) + AW'(c) + AW'(nb);
            bcs_pkg::MODE_PERIODIC: s = AW'(w) + AW'(c) + AW'(c) + AW'(nb);
            default:                s = AW'(c) <<< 2;
        endcase
        return SW'(s >>> 2);
    endfunction

    logic signed [AW-1:0] sum_mid;
    logic signed [AW-1:0] sum_wrap;
    bcs_pkg::t_result     res [bcs_pkg::MAX_RESULTS];
    logic [bcs_pkg::MAX_RESULTS-1:0] res_v;
    logic [1:0]           off [bcs_pkg::MAX_RESULTS];
    logic [1:0]           n_push;

    assign sum_mid  = AW'(r_older) + AW'(r_prev) + AW'(r_prev) + AW'(x);
    assign sum_wrap = AW'(x) + AW'(r_first) + AW'(r_first) + AW'(second_eff);

    always_comb begin
        // first slot: left end at sample one, interior cell after that
        res_v[0] = (k_is1 && !held) || (!k_is0 && !k_is1);
        res[0].frame_end = 1'b0;
        if (k_is1) begin
            res[0].index = '0;
            res[0].value = f_end(r_left_mode, r_first, x, '0);
        end else begin
            res[0].index = bcs_pkg::IDX_W'(r_cnt - 1'b1);
            res[0].value = SW'(sum_mid >>> 2);
        end
        // right end
        res_v[1]         = last;
        res[1].index     = bcs_pkg::IDX_W'(r_cnt);
        res[1].value     = f_end(r_right_mode, x, r_prev, r_first);
        res[1].frame_end = !held;
        // held-back cell 0 under periodic left end
        res_v[2]         = last && held;
        res[2].index     = '0;
        res[2].value     = SW'(sum_wrap >>> 2);
        res[2].frame_end = 1'b1;

        off[0] = 2'd0;
        off[1] = {1'b0, res_v[0]};
        off[2] = {1'b0, res_v[0]} + {1'b0, res_v[1]};
        n_push = accept ? off[2] + {1'b0, res_v[2]} : 2'd0;
    end

    // result queue
    bcs_pkg::t_result r_queue [bcs_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [QC_W-1:0]  r_qcnt;
    logic             pop;
    bcs_pkg::t_result head;

    assign pop        = o_m_tvalid && i_m_tready;
    // room for the largest burst of one request
    assign o_s_tready = (r_qcnt <= QC_W'(bcs_pkg::QUEUE_DEPTH - bcs_pkg::MAX_RESULTS));

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < bcs_pkg::MAX_RESULTS; j++) begin
            if (accept && res_v[j])
                r_queue[PTR_W'(r_wp + PTR_W'(off[j]))] <= res[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_qcnt <= '0;
        end else begin
            r_wp   <= r_wp + PTR_W'(n_push);
            r_rp   <= r_rp + PTR_W'(pop);
            r_qcnt <= r_qcnt + QC_W'(n_push) - QC_W'(pop);
        end
    end

    assign head       = r_queue[r_rp];
    assign o_m_tvalid = (r_qcnt != '0);
    assign o_m_tdata  = {{(bcs_pkg::M_TDATA_W - SW - bcs_pkg::IDX_W){1'b0}},
                         head.value, head.index};
    assign o_m_tlast  = head.frame_end;

    // checks
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qcnt <= QC_W'(bcs_pkg::QUEUE_DEPTH))
        else $error("result queue overflow");

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && last) |=> (r_cnt == '0))
        else $error("counter not cleared after frame end");

    a_close_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && last) |-> (n_push >= 2'd2))
        else $error("frame end gave fewer than two results");

    a_mid_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !last) |-> (n_push <= 2'd1))
        else $error("mid-frame sample gave more than one result");

endmodule
